// ===== design/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, codes and helpers of the UTF-8 decoder with raw fallback.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned TDATA_OUT_W = 24;

	localparam logic [2:0] LEN_BAD   = 3'd0;
	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	typedef enum logic [1:0] {
		SEL_END,
		SEL_PEND,
		SEL_CP,
		SEL_FRESH
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		emit_sel_t sel;
		logic      last;
		logic [1:0] idx;
		logic      clr_cnt;
		logic      start;
		logic      append;
		logic      set_ended;
	} dp_cmd_t;

	typedef struct packed {
		logic       ended;
		logic       eos;
		logic [1:0] cnt;
		logic       b_cont;
		logic       b_single;
		logic       b_bad;
		logic       complete;
		logic       out_free;
	} dp_stat_t;

	function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
		logic [2:0] len;
		len = LEN_BAD;
		if ((b & 8'h80) == 8'h00)      len = LEN_ONE;
		else if ((b & 8'he0) == 8'hc0) len = LEN_TWO;
		else if ((b & 8'hf0) == 8'he0) len = LEN_THREE;
		else if ((b & 8'hf8) == 8'hf0) len = LEN_FOUR;
		return len;
	endfunction

endpackage

// ===== design/utf8d_dp.sv =====
// ----------------------------------------------------------------------------
// utf8d_dp
// Datapath: input latch, pending byte store, code point assembly and the
// output register of the result stream.
// ----------------------------------------------------------------------------
module utf8d_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           in_byte,
	input  logic                 in_eos,
	input  utf8d_pkg::dp_cmd_t   cmd,
	output utf8d_pkg::dp_stat_t  stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [20:0]          out_cp,
	output logic                 out_raw,
	output logic                 out_end,
	output logic                 out_last
);
	import utf8d_pkg::*;

	logic [BYTE_W-1:0] b_q;
	logic              eos_q;
	logic [BYTE_W-1:0] p_q [3];
	logic [1:0]        cnt_q;
	logic              ended_q;

	logic              ovalid_q;
	logic [CP_W-1:0]   ocp_q;
	logic              oraw_q;
	logic              oend_q;
	logic              olast_q;

	logic [2:0]        b_len;
	logic [2:0]        need;
	logic [CP_W-1:0]   cp_dec;
	logic [BYTE_W-1:0] p_sel;
	logic [CP_W-1:0]   emit_cp;
	logic              emit_raw;
	logic              emit_end;
	logic              out_free;

	assign b_len    = lead_len(b_q);
	assign need     = lead_len(p_q[0]);
	assign out_free = !ovalid_q || out_ready;

	always_comb begin
		case (need)
			LEN_FOUR:  cp_dec = {p_q[0][2:0], p_q[1][5:0], p_q[2][5:0], b_q[5:0]};
			LEN_THREE: cp_dec = {5'd0, p_q[0][3:0], p_q[1][5:0], b_q[5:0]};
			default:   cp_dec = {10'd0, p_q[0][4:0], b_q[5:0]};
		endcase
	end

	always_comb begin
		case (cmd.idx)
			2'd0:    p_sel = p_q[0];
			2'd1:    p_sel = p_q[1];
			default: p_sel = p_q[2];
		endcase
	end

	always_comb begin
		emit_cp  = '0;
		emit_raw = 1'b0;
		emit_end = 1'b0;
		case (cmd.sel)
			SEL_END: begin
				emit_end = 1'b1;
			end
			SEL_PEND: begin
				emit_cp  = {13'd0, p_sel};
				emit_raw = 1'b1;
			end
			SEL_CP: begin
				emit_cp = cp_dec;
			end
			SEL_FRESH: begin
				emit_cp  = {13'd0, b_q};
				emit_raw = (b_len == LEN_BAD);
			end
			default: begin
				emit_cp = '0;
			end
		endcase
	end

	always_comb begin
		stat.ended    = ended_q;
		stat.eos      = eos_q;
		stat.cnt      = cnt_q;
		stat.b_cont   = (b_q[7:6] == 2'b10);
		stat.b_single = (b_len == LEN_ONE);
		stat.b_bad    = (b_len == LEN_BAD);
		stat.complete = (({1'b0, cnt_q} + 3'd1) >= need);
		stat.out_free = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b_q   <= in_byte;
			eos_q <= in_eos;
		end
		if (cmd.start) begin
			p_q[0] <= b_q;
		end else if (cmd.append) begin
			case (cnt_q)
				2'd1:    p_q[1] <= b_q;
				default: p_q[2] <= b_q;
			endcase
		end
		if (cmd.emit && out_free) begin
			ocp_q   <= emit_cp;
			oraw_q  <= emit_raw;
			oend_q  <= emit_end;
			olast_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			ended_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				cnt_q <= 2'd1;
			end else if (cmd.append) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (cmd.clr_cnt || cmd.set_ended) begin
				cnt_q <= 2'd0;
			end
			if (cmd.set_ended) begin
				ended_q <= 1'b1;
			end
			if (cmd.emit && out_free) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_cp    = ocp_q;
	assign out_raw   = oraw_q;
	assign out_end   = oend_q;
	assign out_last  = olast_q;

`ifndef SYNTHESIS
	a_pend_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (need >= LEN_TWO))
		else $error("pending sequence without a multi-byte lead");

	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |=> ended_q)
		else $error("end of stream flag cleared");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && oend_q) |-> (ocp_q == '0 && !oraw_q && olast_q))
		else $error("end marker result malformed");

	a_ended_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> (cnt_q == 2'd0))
		else $error("bytes pending after end of stream");
`endif

endmodule

// ===== design/utf8d_ctrl.sv =====
// ----------------------------------------------------------------------------
// utf8d_ctrl
// Controller: accepts one byte request, decides its outcome and sequences
// the result writes into the datapath output register.
// ----------------------------------------------------------------------------
module utf8d_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  utf8d_pkg::dp_stat_t  stat,
	output utf8d_pkg::dp_cmd_t   cmd
);
	import utf8d_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FLUSH,
		ST_FRESH,
		ST_DONE,
		ST_EOSRAW,
		ST_END
	} state_t;

	state_t     state_q;
	logic [1:0] idx_q;
	logic       last_idx;
	logic       b_lead;

	assign last_idx = (idx_q == (stat.cnt - 2'd1));
	assign b_lead   = !stat.b_single && !stat.b_bad;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.sel = SEL_END;
		cmd.idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_DECIDE: begin
				if (!stat.ended && !stat.eos) begin
					if (stat.cnt == 2'd0) begin
						cmd.start = b_lead;
					end else if (stat.b_cont) begin
						cmd.append = !stat.complete;
					end
				end
			end
			ST_FLUSH: begin
				cmd.emit = stat.out_free;
				cmd.sel  = SEL_PEND;
				cmd.last = last_idx && b_lead;
				if (stat.out_free && last_idx) begin
					cmd.start   = b_lead;
					cmd.clr_cnt = !b_lead;
				end
			end
			ST_FRESH: begin
				cmd.emit = stat.out_free;
				cmd.sel  = SEL_FRESH;
				cmd.last = 1'b1;
			end
			ST_DONE: begin
				cmd.emit    = stat.out_free;
				cmd.sel     = SEL_CP;
				cmd.last    = 1'b1;
				cmd.clr_cnt = stat.out_free;
			end
			ST_EOSRAW: begin
				cmd.emit = stat.out_free;
				cmd.sel  = SEL_PEND;
				cmd.idx  = 2'd0;
			end
			ST_END: begin
				cmd.emit      = stat.out_free;
				cmd.sel       = SEL_END;
				cmd.last      = 1'b1;
				cmd.set_ended = stat.out_free;
			end
			default: begin
				cmd.sel = SEL_END;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					idx_q <= 2'd0;
					if (stat.ended) begin
						state_q <= ST_END;
					end else if (stat.eos) begin
						state_q <= (stat.cnt != 2'd0) ? ST_EOSRAW : ST_END;
					end else if (stat.cnt == 2'd0) begin
						state_q <= b_lead ? ST_IDLE : ST_FRESH;
					end else if (stat.b_cont) begin
						state_q <= stat.complete ? ST_DONE : ST_IDLE;
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (stat.out_free) begin
						if (last_idx) begin
							state_q <= b_lead ? ST_IDLE : ST_FRESH;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				ST_FRESH, ST_DONE, ST_END: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				ST_EOSRAW: begin
					if (stat.out_free) state_q <= ST_END;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DECIDE))
		else $error("accepted request not decided");

	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (stat.cnt != 2'd0 && idx_q < stat.cnt))
		else $error("flush index outside pending bytes");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.start, cmd.append, cmd.clr_cnt}) <= 1)
		else $error("conflicting pending updates");
`endif

endmodule

// ===== design/utf8_decoder_raw_fallback_core.sv =====
// ----------------------------------------------------------------------------
// utf8_decoder_raw_fallback_core
// UTF-8 decoder with raw byte fallback on broken or stray sequences.
// ----------------------------------------------------------------------------
// One byte request is taken at a time. The controller decides each byte in
// its decide state, then writes one result per cycle while the output
// register is free; a byte that only extends a pending sequence returns to
// idle from the decide state (at most 4 results per byte, on a broken 4-byte
// sequence). The output register lets the next byte be taken while the last
// result still waits. An end-of-stream request flushes the first pending
// byte raw, drops the rest and gives an end marker; every request after it
// gives one end marker until reset.
module utf8_decoder_raw_fallback_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic [1:0]  m_tuser,   // [0] raw_passthrough, [1] end_marker
	output logic        m_tlast    // last_of_run
);
	import utf8d_pkg::*;

	dp_cmd_t         cmd;
	dp_stat_t        stat;
	logic [CP_W-1:0] cp;
	logic            raw;
	logic            endm;

	utf8d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	utf8d_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.in_eos    (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_cp    (cp),
		.out_raw   (raw),
		.out_end   (endm),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(TDATA_OUT_W - CP_W){1'b0}}, cp};
	assign m_tuser = {endm, raw};

endmodule
